// File: hdl/modular_exponentiation_rsa_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
//   Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_RSA_ASSERT_SVH
`define MODULAR_EXPONENTIATION_RSA_ASSERT_SVH

// checked only out of reset
`define MEXP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define MEXP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
//   Types and constants of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODULUS  = 2'd0,
    CFG_PUB_EXP  = 2'd1,
    CFG_PRIV_EXP = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_WAIT,
    ST_CHECK,
    ST_MUL
  } state_e;

  localparam logic [31:0] MODULUS_RST  = 32'd2140;
  localparam logic [31:0] PUB_EXP_RST  = 32'd3;
  localparam logic [31:0] PRIV_EXP_RST = 32'd1343;

endpackage

// File: hdl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
//   Bit-serial interleaved modular multiplier: p = a * b mod m.
//   One bit of a per cycle, MSB first; b must be below m.
// ----------------------------------------------------------------------------
module mexp_modmul #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic [Width:0]   m_i,     // modulus, 2^Width encoded as MSB set
  output logic             done_o,
  output logic [Width-1:0] p_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic             done_q;
  logic [Width-1:0] a_q;
  logic [Width-1:0] b_q;
  logic [Width-1:0] r_q;

  logic [Width+1:0] sum;
  logic [Width+1:0] m1;
  logic [Width+1:0] m2;
  logic [Width+1:0] r_d;

  // r < m and b < m, so 2r + b < 3m: at most two subtractions
  always_comb begin
    sum = {1'b0, r_q, 1'b0} + (a_q[Width-1] ? {2'b00, b_q} : '0);
    m1  = {1'b0, m_i};
    m2  = {m_i, 1'b0};
    if (sum >= m2) begin
      r_d = sum - m2;
    end else if (sum >= m1) begin
      r_d = sum - m1;
    end else begin
      r_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(Width);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (run_q) begin
      a_q <= {a_q[Width-2:0], 1'b0};
      r_q <= r_d[Width-1:0];
    end
  end

  assign done_o = done_q;
  assign p_o    = r_q;

endmodule

// File: hdl/modular_exponentiation_rsa.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_rsa
//   RSA modular exponentiation, right-to-left square and multiply.
// ----------------------------------------------------------------------------
// Usage:
//   A word (command_i, value_i) is taken at a clock edge with start high and
//   busy low. command_i selects the public exponent (encrypt) or the private
//   exponent (decrypt). busy stays high while the word is worked on; result_o
//   then shows value^exponent mod modulus, marked by done_o for one cycle.
//   The receiver cannot stall; busy falls in the cycle done_o is shown, so
//   the next word may be started right then.
//   The base is first reduced; then, up to the top set exponent bit, each
//   exponent bit runs two bit-serial modular multipliers side by side, one
//   operand bit per cycle.
//   Configuration writes (cfg_valid_i/cfg_ready_o) are taken while idle.
//   Reset loads modulus 2140, public exponent 3, private exponent 1343.
// ----------------------------------------------------------------------------
module modular_exponentiation_rsa
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [31:0] result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned W = OPERAND_WIDTH;

  state_e         state_q, state_d;
  logic [W-1:0]   modulus_q;
  logic [W-1:0]   pub_exp_q;
  logic [W-1:0]   priv_exp_q;
  logic [W-1:0]   ex_q;
  logic [W-1:0]   base_q;
  logic [W-1:0]   acc_q;
  logic [31:0]    result_q;
  logic           done_q;

  logic [W:0]     m_ext;
  logic [W-1:0]   one_red;
  logic [W-1:0]   sq_b;
  logic           red_start;
  logic           mul_start;
  logic           finish;
  logic           sq_done;
  logic           ml_done;
  logic [W-1:0]   sq_p;
  logic [W-1:0]   ml_p;

  // modulus zero stands for 2^W
  assign m_ext   = {(modulus_q == '0), modulus_q};
  assign one_red = {{(W-1){1'b0}}, (modulus_q != W'(1))};
  assign sq_b    = (state_q == ST_RED) ? one_red : base_q;

  always_comb begin
    state_d   = state_q;
    red_start = 1'b0;
    mul_start = 1'b0;
    finish    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        red_start = 1'b1;
        state_d   = ST_RED_WAIT;
      end
      ST_RED_WAIT: begin
        if (sq_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (ex_q == '0) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sq_done && ml_done) begin
          state_d = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      modulus_q  <= MODULUS_RST[W-1:0];
      pub_exp_q  <= PUB_EXP_RST[W-1:0];
      priv_exp_q <= PRIV_EXP_RST[W-1:0];
    end else begin
      state_q <= state_d;
      done_q  <= finish;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MODULUS:  modulus_q  <= cfg_data_i[W-1:0];
          CFG_PUB_EXP:  pub_exp_q  <= cfg_data_i[W-1:0];
          CFG_PRIV_EXP: priv_exp_q <= cfg_data_i[W-1:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      ex_q   <= (cmd_e'(command_i) == CMD_DECRYPT) ? priv_exp_q : pub_exp_q;
      base_q <= value_i[W-1:0];
      acc_q  <= W'(1);
    end
    if (state_q == ST_RED_WAIT && sq_done) begin
      base_q <= sq_p;
    end
    if (state_q == ST_MUL && sq_done && ml_done) begin
      base_q <= sq_p;
      if (ex_q[0]) begin
        acc_q <= ml_p;
      end
      ex_q <= ex_q >> 1;
    end
    if (finish) begin
      result_q <= 32'(acc_q);
    end
  end

  // squaring unit, also reduces the raw base as base * 1 mod m
  mexp_modmul #(
    .Width (W)
  ) u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start | mul_start),
    .a_i     (base_q),
    .b_i     (sq_b),
    .m_i     (m_ext),
    .done_o  (sq_done),
    .p_o     (sq_p)
  );

  // accumulator unit, runs in lockstep with the squaring unit
  mexp_modmul #(
    .Width (W)
  ) u_ml (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (acc_q),
    .b_i     (base_q),
    .m_i     (m_ext),
    .done_o  (ml_done),
    .p_o     (ml_p)
  );

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign result_o    = result_q;
  assign cfg_ready_o = ~busy;

endmodule

// File: hdl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
//   Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_rsa_assert.svh"

module mexp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  `MEXP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !busy && !done_o, "busy or done during reset")

  `MEXP_ASSERT(a_accept_busy, start && !busy |=> busy && !done_o, "accepted word not in work")

  `MEXP_ASSERT(a_done_idle, done_o |-> !busy && $fell(busy), "result not at end of work")

  `MEXP_ASSERT(a_done_single, done_o |=> !done_o, "result strobe repeated")

  `MEXP_ASSERT(a_fall_done, $fell(busy) |-> done_o, "work ended without result")

endmodule

bind modular_exponentiation_rsa mexp_checker u_mexp_checker (.*);
